[src/led_status_pattern_generator_assert.svh]
// ---------------------------------------------------------------------------
// LED status pattern generator assertion macros
// Shared concurrent checks, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef LED_STATUS_PATTERN_GENERATOR_ASSERT_SVH
`define LED_STATUS_PATTERN_GENERATOR_ASSERT_SVH

// The condition holds at every clock edge.
`define LSPG_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("%m: check failed");

// When the antecedent holds, the consequent holds at the next edge.
`define LSPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

[src/lspg_pkg.sv]
// ---------------------------------------------------------------------------
// LED status pattern generator package
// Mode and register codes, pattern constants and the queue word type.
// ---------------------------------------------------------------------------
package lspg_pkg;

  localparam int PIXEL_COUNT = 2;
  localparam int FIFO_DEPTH  = 4;
  localparam int LEVEL_W     = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 3;

  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_BLUE    = 3'd1;
  localparam logic [2:0] MODE_STANDBY = 3'd2;
  localparam logic [2:0] MODE_GREEN   = 3'd3;
  localparam logic [2:0] MODE_PURPLE  = 3'd4;
  localparam logic [2:0] MODE_RED     = 3'd5;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE      = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEARTBEAT = 1'd1;

  localparam logic [63:0] RECIP_ONE = 64'd1 << 32;

  localparam logic [31:0] AURA_OFFSET = 32'd500;

  localparam logic [LEVEL_W-1:0] STATUS_PEAK  = 6'd48;
  localparam logic [LEVEL_W-1:0] AURA_PEAK    = 6'd28;
  localparam logic [LEVEL_W-1:0] STANDBY_PEAK = 6'd18;
  localparam logic [LEVEL_W-1:0] HB_PEAK      = 6'd28;

  localparam logic [12:0] HB_PERIOD          = 13'd1800;
  localparam logic [12:0] BLUE_STATUS_PERIOD = 13'd2000;
  localparam logic [12:0] BLUE_AURA_PERIOD   = 13'd3200;
  localparam logic [12:0] STANDBY_PERIOD     = 13'd5000;
  localparam logic [12:0] GREEN_AURA_PERIOD  = 13'd2600;
  localparam logic [12:0] PURPLE_DIV         = 13'd120;
  localparam logic [12:0] RED_DIV            = 13'd200;

  localparam logic [12:0] HB_HALF          = HB_PERIOD / 13'd2;
  localparam logic [12:0] BLUE_STATUS_HALF = BLUE_STATUS_PERIOD / 13'd2;
  localparam logic [12:0] BLUE_AURA_HALF   = BLUE_AURA_PERIOD / 13'd2;
  localparam logic [12:0] STANDBY_HALF     = STANDBY_PERIOD / 13'd2;
  localparam logic [12:0] GREEN_AURA_HALF  = GREEN_AURA_PERIOD / 13'd2;

  localparam logic [31:0] HB_RECIP          = 32'(RECIP_ONE / 64'(HB_PERIOD));
  localparam logic [31:0] BLUE_STATUS_RECIP = 32'(RECIP_ONE / 64'(BLUE_STATUS_PERIOD));
  localparam logic [31:0] BLUE_AURA_RECIP   = 32'(RECIP_ONE / 64'(BLUE_AURA_PERIOD));
  localparam logic [31:0] STANDBY_RECIP     = 32'(RECIP_ONE / 64'(STANDBY_PERIOD));
  localparam logic [31:0] GREEN_AURA_RECIP  = 32'(RECIP_ONE / 64'(GREEN_AURA_PERIOD));
  localparam logic [31:0] PURPLE_RECIP      = 32'(RECIP_ONE / 64'(PURPLE_DIV));
  localparam logic [31:0] RED_RECIP         = 32'(RECIP_ONE / 64'(RED_DIV));

  localparam logic [31:0] HB_HALF_RECIP          = 32'(RECIP_ONE / 64'(HB_HALF));
  localparam logic [31:0] BLUE_STATUS_HALF_RECIP = 32'(RECIP_ONE / 64'(BLUE_STATUS_HALF));
  localparam logic [31:0] BLUE_AURA_HALF_RECIP   = 32'(RECIP_ONE / 64'(BLUE_AURA_HALF));
  localparam logic [31:0] STANDBY_HALF_RECIP     = 32'(RECIP_ONE / 64'(STANDBY_HALF));
  localparam logic [31:0] GREEN_AURA_HALF_RECIP  = 32'(RECIP_ONE / 64'(GREEN_AURA_HALF));

  typedef struct packed {
    logic               flash;
    logic [LEVEL_W-1:0] aura;
    logic [LEVEL_W-1:0] strip;
    logic [LEVEL_W-1:0] hb;
  } levels_t;

endpackage

[src/lspg_cdiv.sv]
// ---------------------------------------------------------------------------
// Constant divider
// Three-stage quotient and remainder by a fixed divisor using its reciprocal.
// ---------------------------------------------------------------------------
module lspg_cdiv (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] recip,
  input  logic [12:0] dvs,
  output logic [31:0] quo,
  output logic [12:0] rem
);

  logic [63:0] prod;
  logic [31:0] num1;
  logic [31:0] num2;
  logic [31:0] q2;
  logic [31:0] qp2;
  logic [12:0] dvs1;
  logic [12:0] dvs2;
  logic [13:0] r_est;

  // The estimated quotient is short by at most one, so the first remainder
  // stays below twice the divisor.
  assign r_est = num2[13:0] - qp2[13:0];

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 64'(num) * 64'(recip);
      num1 <= num;
      dvs1 <= dvs;
      q2   <= prod[63:32];
      qp2  <= prod[63:32] * {19'd0, dvs1};
      num2 <= num1;
      dvs2 <= dvs1;
      if (r_est >= {1'b0, dvs2}) begin
        quo <= q2 + 32'd1;
        rem <= 13'(r_est - {1'b0, dvs2});
      end else begin
        quo <= q2;
        rem <= r_est[12:0];
      end
    end
  end

endmodule

[src/lspg_front.sv]
// ---------------------------------------------------------------------------
// Pattern front end
// Reduces each time stamp to pulse levels and the flash phase in seven stages.
// ---------------------------------------------------------------------------
`include "led_status_pattern_generator_assert.svh"

module lspg_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       time_ms,
  input  logic [2:0]        mode,
  output logic              out_valid,
  input  logic              out_ready,
  output lspg_pkg::levels_t levels
);

  localparam int LANES      = 3;
  localparam int LANE_HB    = 0;
  localparam int LANE_STRIP = 1;
  localparam int LANE_AURA  = 2;

  logic                         en;
  logic [7:1]                   vld;
  logic [3:0]                   fl_pipe;
  logic [31:0]                  num    [LANES];
  logic [31:0]                  recip  [LANES];
  logic [12:0]                  per    [LANES];
  logic [12:0]                  half   [LANES];
  logic [31:0]                  hrecip [LANES];
  logic [lspg_pkg::LEVEL_W-1:0] peak   [LANES];
  logic [31:0]                  mq     [LANES];
  logic [12:0]                  ph     [LANES];
  logic [18:0]                  x4     [LANES];
  logic [31:0]                  lq     [LANES];

  assign en        = !vld[7] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[7];

  always_comb begin
    num[LANE_HB]    = time_ms;
    recip[LANE_HB]  = lspg_pkg::HB_RECIP;
    per[LANE_HB]    = lspg_pkg::HB_PERIOD;
    half[LANE_HB]   = lspg_pkg::HB_HALF;
    hrecip[LANE_HB] = lspg_pkg::HB_HALF_RECIP;
    peak[LANE_HB]   = lspg_pkg::HB_PEAK;

    num[LANE_AURA]    = time_ms + lspg_pkg::AURA_OFFSET;
    recip[LANE_AURA]  = lspg_pkg::BLUE_AURA_RECIP;
    per[LANE_AURA]    = lspg_pkg::BLUE_AURA_PERIOD;
    half[LANE_AURA]   = lspg_pkg::BLUE_AURA_HALF;
    hrecip[LANE_AURA] = lspg_pkg::BLUE_AURA_HALF_RECIP;
    peak[LANE_AURA]   = lspg_pkg::AURA_PEAK;

    num[LANE_STRIP]    = time_ms;
    recip[LANE_STRIP]  = lspg_pkg::BLUE_STATUS_RECIP;
    per[LANE_STRIP]    = lspg_pkg::BLUE_STATUS_PERIOD;
    half[LANE_STRIP]   = lspg_pkg::BLUE_STATUS_HALF;
    hrecip[LANE_STRIP] = lspg_pkg::BLUE_STATUS_HALF_RECIP;
    peak[LANE_STRIP]   = lspg_pkg::STATUS_PEAK;
    unique case (mode) inside
      lspg_pkg::MODE_STANDBY: begin
        recip[LANE_STRIP]  = lspg_pkg::STANDBY_RECIP;
        per[LANE_STRIP]    = lspg_pkg::STANDBY_PERIOD;
        half[LANE_STRIP]   = lspg_pkg::STANDBY_HALF;
        hrecip[LANE_STRIP] = lspg_pkg::STANDBY_HALF_RECIP;
        peak[LANE_STRIP]   = lspg_pkg::STANDBY_PEAK;
      end
      lspg_pkg::MODE_GREEN: begin
        recip[LANE_STRIP]  = lspg_pkg::GREEN_AURA_RECIP;
        per[LANE_STRIP]    = lspg_pkg::GREEN_AURA_PERIOD;
        half[LANE_STRIP]   = lspg_pkg::GREEN_AURA_HALF;
        hrecip[LANE_STRIP] = lspg_pkg::GREEN_AURA_HALF_RECIP;
        peak[LANE_STRIP]   = lspg_pkg::AURA_PEAK;
      end
      lspg_pkg::MODE_PURPLE: begin
        recip[LANE_STRIP] = lspg_pkg::PURPLE_RECIP;
        per[LANE_STRIP]   = lspg_pkg::PURPLE_DIV;
      end
      lspg_pkg::MODE_RED: begin
        recip[LANE_STRIP] = lspg_pkg::RED_RECIP;
        per[LANE_STRIP]   = lspg_pkg::RED_DIV;
      end
      default: begin
      end
    endcase
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [12:0] span;

    lspg_cdiv u_mod (
      .clk   (clk),
      .en    (en),
      .num   (num[l]),
      .recip (recip[l]),
      .dvs   (per[l]),
      .quo   (mq[l]),
      .rem   (ph[l])
    );

    // Distance from the nearer end of the period gives the triangle.
    assign span = (ph[l] < half[l]) ? ph[l] : per[l] - ph[l];

    always_ff @(posedge clk) begin
      if (en) begin
        x4[l] <= {6'd0, span} * {13'd0, peak[l]};
      end
    end

    lspg_cdiv u_lvl (
      .clk   (clk),
      .en    (en),
      .num   ({13'd0, x4[l]}),
      .recip (hrecip[l]),
      .dvs   (half[l]),
      .quo   (lq[l]),
      .rem   ()
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_pipe <= {fl_pipe[2:0], mq[LANE_STRIP][0]};
    end
  end

  assign levels.flash = fl_pipe[3];
  assign levels.hb    = lq[LANE_HB][lspg_pkg::LEVEL_W-1:0];
  assign levels.strip = lq[LANE_STRIP][lspg_pkg::LEVEL_W-1:0];
  assign levels.aura  = lq[LANE_AURA][lspg_pkg::LEVEL_W-1:0];

  `LSPG_ASSERT_NEXT(a_front_stall_holds, vld[7] && !out_ready, vld[7])

endmodule

[src/lspg_fifo.sv]
// ---------------------------------------------------------------------------
// Level queue
// Short queue of level words between the front end and the output stage.
// ---------------------------------------------------------------------------
`include "led_status_pattern_generator_assert.svh"

module lspg_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lspg_pkg::levels_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lspg_pkg::levels_t out_data
);

  localparam int AW = $clog2(lspg_pkg::FIFO_DEPTH);
  localparam logic [AW:0] CNT_FULL = (AW+1)'(lspg_pkg::FIFO_DEPTH);
  localparam logic [AW:0] CNT_ONE  = (AW+1)'(1);

  lspg_pkg::levels_t mem [lspg_pkg::FIFO_DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW:0]       count;
  logic              wr;
  logic              rd;

  assign in_ready  = (count != CNT_FULL);
  assign out_valid = (count != '0);
  assign wr        = in_valid && in_ready;
  assign rd        = out_valid && out_ready;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (wr && !rd) begin
        count <= count + CNT_ONE;
      end else if (rd && !wr) begin
        count <= count - CNT_ONE;
      end
    end
  end

  `LSPG_ASSERT_ALWAYS(a_fifo_count_bound, count <= CNT_FULL)
  `LSPG_ASSERT_NEXT(a_fifo_count_up, wr && !rd, count == $past(count) + CNT_ONE)
  `LSPG_ASSERT_NEXT(a_fifo_count_down, rd && !wr, count == $past(count) - CNT_ONE)

endmodule

[src/lspg_back.sv]
// ---------------------------------------------------------------------------
// Pattern back end
// Maps levels to the three pixels by mode and holds the output word.
// ---------------------------------------------------------------------------
module lspg_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [2:0]        mode,
  input  logic              heartbeat_enable,
  input  logic              in_valid,
  output logic              in_ready,
  input  lspg_pkg::levels_t levels,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [71:0]       out_data
);

  localparam bit HAS_STATUS = lspg_pkg::PIXEL_COUNT > 0;
  localparam bit HAS_AURA   = lspg_pkg::PIXEL_COUNT > 1;

  logic [71:0] out_data_next;
  logic [7:0]  hb;
  logic [7:0]  sp;
  logic [7:0]  au;
  logic [7:0]  on;
  logic [7:0]  st_r, st_g, st_b;
  logic [7:0]  au_r, au_g, au_b;
  logic [7:0]  hb_r, hb_g, hb_b;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    hb = {2'd0, levels.hb};
    sp = {2'd0, levels.strip};
    au = {2'd0, levels.aura};
    on = levels.flash ? {2'd0, lspg_pkg::STATUS_PEAK} : 8'd0;
    hb_r = '0; hb_g = '0; hb_b = '0;
    st_r = '0; st_g = '0; st_b = '0;
    au_r = '0; au_g = '0; au_b = '0;

    if (heartbeat_enable) begin
      unique case (mode) inside
        lspg_pkg::MODE_GREEN: hb_g = hb;
        lspg_pkg::MODE_BLUE, lspg_pkg::MODE_STANDBY: hb_b = hb;
        lspg_pkg::MODE_PURPLE: begin
          hb_r = hb >> 1;
          hb_b = hb;
        end
        default: hb_r = hb;
      endcase
    end

    unique case (mode) inside
      lspg_pkg::MODE_BLUE: begin
        st_b = sp;
        au_b = au;
      end
      lspg_pkg::MODE_STANDBY: begin
        st_b = sp;
        au_b = sp >> 1;
      end
      lspg_pkg::MODE_GREEN: begin
        st_g = {2'd0, lspg_pkg::STATUS_PEAK};
        au_g = sp;
        au_b = sp >> 1;
      end
      lspg_pkg::MODE_PURPLE: begin
        st_r = on >> 1;
        st_b = on;
        au_r = on >> 1;
        au_b = on;
      end
      lspg_pkg::MODE_RED: begin
        st_r = on;
        au_r = on >> 1;
      end
      default: begin
      end
    endcase

    if (!HAS_STATUS) begin
      st_r = '0; st_g = '0; st_b = '0;
    end
    if (!HAS_AURA) begin
      au_r = '0; au_g = '0; au_b = '0;
    end

    out_data_next = {hb_b, hb_g, hb_r, au_b, au_g, au_r, st_b, st_g, st_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= out_data_next;
    end
  end

endmodule

[src/led_status_pattern_generator.sv]
// ---------------------------------------------------------------------------
// LED status pattern generator
// Turns millisecond time stamps into status, aura and heartbeat pixel levels.
// ---------------------------------------------------------------------------
// Usage:
// Each word on the s_axis channel is a 32-bit time stamp in milliseconds.
// For every accepted word one word leaves on m_axis with nine 8-bit levels.
// The pattern follows the mode register and heartbeat_enable, which are set
// through the cfg_* write port. The user must set them only while no word is in
// flight; the block itself does not enforce this. A word passes through
// the front end (two three-stage reciprocal dividers and the triangle
// multiply), the four-word queue and the output register.
// One word per cycle is sustained while m_axis_tready stays high.
// Reset sets the mode to off, enables the heartbeat and empties the pipeline
// and the queue.
// While m_axis_tready is low the output word holds, the queue fills, and once
// it is full the front end stops and s_axis_tready falls.
// ---------------------------------------------------------------------------
module led_status_pattern_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [lspg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lspg_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // time_ms[31:0]
  input  logic [31:0]                      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status_red, status_green, status_blue, aura_red, aura_green, aura_blue,
  // heart_red, heart_green, heart_blue, 8 bits each from bit 0 up
  output logic [71:0]                      m_axis_tdata
);

  logic [2:0]        mode;
  logic              heartbeat_enable;
  logic              front_valid;
  logic              front_ready;
  lspg_pkg::levels_t front_levels;
  logic              queue_valid;
  logic              queue_ready;
  lspg_pkg::levels_t queue_levels;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= lspg_pkg::MODE_OFF;
      heartbeat_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        lspg_pkg::REG_MODE:      mode <= cfg_data[2:0];
        lspg_pkg::REG_HEARTBEAT: heartbeat_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  lspg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .time_ms   (s_axis_tdata),
    .mode      (mode),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .levels    (front_levels)
  );

  lspg_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_levels),
    .out_valid (queue_valid),
    .out_ready (queue_ready),
    .out_data  (queue_levels)
  );

  lspg_back u_back (
    .clk              (clk),
    .rst              (rst),
    .mode             (mode),
    .heartbeat_enable (heartbeat_enable),
    .in_valid         (queue_valid),
    .in_ready         (queue_ready),
    .levels           (queue_levels),
    .out_valid        (m_axis_tvalid),
    .out_ready        (m_axis_tready),
    .out_data         (m_axis_tdata)
  );

endmodule
